>>> hw/rtl/acpt_pkg.sv
// Shared types, codes and the type-to-type notification mask of the AABB pair table.
// Depends on nothing; the core, acpt_ctrl and acpt_dp import it.
package acpt_pkg;

	localparam int unsigned NUM_KINDS = 9;
	localparam int unsigned BOX_BITS  = 62;
	localparam int unsigned ATTR_BITS = 5;

	typedef enum logic [1:0] {
		MODE_ADD   = 2'd0,
		MODE_ERASE = 2'd1,
		MODE_MOVE  = 2'd2,
		MODE_SWEEP = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ITEM_STATUS = 2'd0,
		ITEM_PAIR   = 2'd1,
		ITEM_DONE   = 2'd2
	} item_kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Bit c of row r: an object of type r is told when it hits type c.
	localparam logic [NUM_KINDS-1:0] TYPE_MASK [NUM_KINDS] = '{
		9'h000, 9'h060, 9'h190, 9'h060, 9'h064, 9'h01A, 9'h01A, 9'h064, 9'h005
	};

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ld;    // capture the accepted input beat
		logic row_rd;   // read the row slot and arm the slot counter
		logic row_ld;   // latch the row slot's entry
		logic advance;  // retire the compare stage and read the next slot
		logic commit;   // apply add, erase or move, or an empty-row sweep, and post its status beat
		logic fin;      // post the sweep-finished beat
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_live; // sweep request on a used row
		logic out_free;   // the output register can take a beat this cycle
		logic stall;      // the compare stage has a pair but no room to post it
		logic idx_end;    // every later slot has been read
	} sts_t;

	function automatic logic mask_hit(logic [3:0] own_kind, logic [3:0] other_kind);
		logic r;
		r = 1'b0;
		if (own_kind < 4'(NUM_KINDS) && other_kind < 4'(NUM_KINDS)) begin
			r = TYPE_MASK[own_kind][other_kind];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/acpt_req_if.sv
// Request channel of the AABB pair table: valid, ready and one command beat.
// Depends on nothing.
interface acpt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [5:0]  slot;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [14:0] box_w;
	logic [14:0] box_h;
	logic [3:0]  kind;
	logic        has_handler;

	modport source (output valid, mode, slot, pos_x, pos_y, box_w, box_h, kind, has_handler,
		input ready);
	modport sink (input valid, mode, slot, pos_x, pos_y, box_w, box_h, kind, has_handler,
		output ready);
endinterface

>>> hw/rtl/acpt_rsp_if.sv
// Response channel of the AABB pair table: valid, ready and one result beat.
// Depends on nothing.
interface acpt_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] item_kind;
	logic [1:0] status;
	logic [5:0] slot_a;
	logic [5:0] slot_b;
	logic       notify_a;
	logic       notify_b;
	logic       last;

	modport source (output valid, item_kind, status, slot_a, slot_b, notify_a, notify_b, last,
		input ready);
	modport sink (input valid, item_kind, status, slot_a, slot_b, notify_a, notify_b, last,
		output ready);
endinterface

>>> hw/rtl/aabb_collision_pair_table_core.sv
// AABB broad-phase pair table: a table of NUM_SLOTS boxes, each with a type code and a
// handler flag. The req channel carries one command per beat: add a box in the first free
// slot, erase a slot, move a slot's box, or sweep one row against every later used slot.
// The rsp channel returns result beats; last marks the final beat of each command.
// Add, erase, move and a sweep of an empty row give one status beat, loaded into the output
// register once it is free, after the request beat has been captured.
// A sweep of row s first reads the row entry, then reads one later slot from the box memory
// and compares it per cycle while no pair waits for room in the output register, and a
// finishing beat closes the sweep. Each overlapping pair is posted as a pair beat with
// notify flags from the type mask.
// One command is processed at a time; req.ready is high while the sequencer is idle, which
// it also is while the last result still waits in the output register.
// When rsp.ready is low and the output register is full, a pair in the compare stage is
// held and the sweep pauses until the register drains; no beat is dropped or repeated.
// Reset clears all used flags and the output valid flag; no clearing pass is needed, since
// box, type and handler of a slot are written whenever the slot becomes used.
// Depends on acpt_pkg, acpt_req_if, acpt_rsp_if, acpt_ctrl and acpt_dp.
module aabb_collision_pair_table_core
	import acpt_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	acpt_req_if.sink    req,
	acpt_rsp_if.source  rsp
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	// The sequencer owns the request handshake; the datapath owns the output register.
	acpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign req.ready = in_ready;

	acpt_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.req_mode        (req.mode),
		.req_slot        (req.slot),
		.req_pos_x       (req.pos_x),
		.req_pos_y       (req.pos_y),
		.req_box_w       (req.box_w),
		.req_box_h       (req.box_h),
		.req_kind        (req.kind),
		.req_has_handler (req.has_handler),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_item_kind   (rsp.item_kind),
		.out_status      (rsp.status),
		.out_slot_a      (rsp.slot_a),
		.out_slot_b      (rsp.slot_b),
		.out_notify_a    (rsp.notify_a),
		.out_notify_b    (rsp.notify_b),
		.out_last        (rsp.last)
	);

endmodule

>>> hw/rtl/acpt_ctrl.sv
// Sequencer of the AABB pair table: one-hot state machine that issues datapath commands.
// Depends on acpt_pkg.
module acpt_ctrl
	import acpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_EXEC  = 5'b00010,
		S_LOAD  = 5'b00100,
		S_SWEEP = 5'b01000,
		S_FIN   = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.in_ld = 1'b1;
					state_d   = S_EXEC;
				end
			end
			S_EXEC: begin
				if (sts.sweep_live) begin
					cmd.row_rd = 1'b1;
					state_d    = S_LOAD;
				end else if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_LOAD: begin
				cmd.row_ld  = 1'b1;
				cmd.advance = 1'b1;
				state_d     = S_SWEEP;
			end
			S_SWEEP: begin
				if (!sts.stall) begin
					cmd.advance = 1'b1;
					if (sts.idx_end) begin
						state_d = S_FIN;
					end
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/acpt_dp.sv
// Datapath of the AABB pair table: slot table, box and attribute memories, compare stage
// and the output register. Depends on acpt_pkg.
module acpt_dp
	import acpt_pkg::*;
#(
	parameter int unsigned NUM_SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  req_mode,
	input  logic [5:0]  req_slot,
	input  logic [15:0] req_pos_x,
	input  logic [15:0] req_pos_y,
	input  logic [14:0] req_box_w,
	input  logic [14:0] req_box_h,
	input  logic [3:0]  req_kind,
	input  logic        req_has_handler,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_item_kind,
	output logic [1:0]  out_status,
	output logic [5:0]  out_slot_a,
	output logic [5:0]  out_slot_b,
	output logic        out_notify_a,
	output logic        out_notify_b,
	output logic        out_last
);

	localparam int unsigned IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int unsigned CW = $clog2(NUM_SLOTS + 1);

	// Captured request beat.
	mode_t                 mode_q;
	logic [5:0]            slot_q;
	logic [BOX_BITS-1:0]   box_q;
	logic [ATTR_BITS-1:0]  attr_q;

	// Slot table.
	logic [NUM_SLOTS-1:0]  used_q;
	logic [BOX_BITS-1:0]   box_mem  [NUM_SLOTS];
	logic [ATTR_BITS-1:0]  attr_mem [NUM_SLOTS];

	// Row entry and sweep counter.
	logic [BOX_BITS-1:0]   row_box_q;
	logic [ATTR_BITS-1:0]  row_attr_q;
	logic [CW-1:0]         idx_q;

	// Compare stage: registered memory read of one later slot.
	logic                  vld_s1;
	logic [IW-1:0]         idx_s1;
	logic [BOX_BITS-1:0]   rd_box_s1;
	logic [ATTR_BITS-1:0]  rd_attr_s1;

	// Output register.
	logic                  out_valid_q;
	logic [1:0]            out_kind_q;
	logic [1:0]            out_status_q;
	logic [5:0]            out_a_q;
	logic [5:0]            out_b_q;
	logic                  out_na_q;
	logic                  out_nb_q;
	logic                  out_last_q;

	logic                  present;
	logic                  full;
	logic [IW-1:0]         free_idx;
	logic                  overlap;
	logic                  hit;
	logic                  out_free;
	logic                  idx_end;
	logic                  rd_en;
	logic [IW-1:0]         rd_addr;
	logic [IW-1:0]         wr_addr;
	logic                  box_we;
	logic                  attr_we;
	logic                  pair_ld;
	logic [1:0]            st_kind;
	logic [1:0]            st_status;
	logic [5:0]            st_a;

	// Start plus length strictly past the other start, on 18-bit signed values.
	function automatic logic axis_gt(logic [15:0] p, logic [14:0] len, logic [15:0] q);
		logic [17:0] e;
		e = {{2{p[15]}}, p} + {3'b000, len};
		return $signed(e) > $signed({{2{q[15]}}, q});
	endfunction

	always_comb begin
		free_idx = '0;
		full     = 1'b1;
		for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_idx = IW'(i);
				full     = 1'b0;
			end
		end
	end

	assign present = (slot_q < 6'(NUM_SLOTS)) && used_q[slot_q[IW-1:0]];
	assign idx_end = (idx_q == CW'(NUM_SLOTS));
	assign out_free = !out_valid_q || out_ready;

	// Box layout: left [15:0], top [31:16], width [46:32], height [61:47].
	assign overlap =
		axis_gt(row_box_q[31:16], row_box_q[61:47], rd_box_s1[31:16]) &&
		axis_gt(rd_box_s1[31:16], rd_box_s1[61:47], row_box_q[31:16]) &&
		axis_gt(row_box_q[15:0], row_box_q[46:32], rd_box_s1[15:0]) &&
		axis_gt(rd_box_s1[15:0], rd_box_s1[46:32], row_box_q[15:0]);

	assign hit     = vld_s1 && used_q[idx_s1] && overlap;
	assign pair_ld = cmd.advance && hit;

	assign sts.sweep_live = (mode_q == MODE_SWEEP) && present;
	assign sts.out_free   = out_free;
	assign sts.stall      = hit && !out_free;
	assign sts.idx_end    = idx_end;

	assign rd_en   = cmd.row_rd || (cmd.advance && !idx_end);
	assign rd_addr = cmd.row_rd ? slot_q[IW-1:0] : idx_q[IW-1:0];
	assign wr_addr = (mode_q == MODE_ADD) ? free_idx : slot_q[IW-1:0];
	assign box_we  = cmd.commit && (((mode_q == MODE_ADD) && !full) ||
		((mode_q == MODE_MOVE) && present));
	assign attr_we = cmd.commit && (mode_q == MODE_ADD) && !full;

	// Status beat of a single-result command.
	always_comb begin
		st_kind   = ITEM_STATUS;
		st_status = ST_OK;
		st_a      = slot_q;
		unique case (mode_q)
			MODE_ADD: begin
				st_status = full ? ST_FULL : ST_OK;
				st_a      = full ? 6'd0 : 6'(free_idx);
			end
			MODE_ERASE, MODE_MOVE: begin
				st_status = present ? ST_OK : ST_EMPTY;
			end
			MODE_SWEEP: begin
				st_kind   = ITEM_DONE;
				st_status = ST_EMPTY;
			end
			default: begin
				st_kind = ITEM_STATUS;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.in_ld) begin
			mode_q <= mode_t'(req_mode);
			slot_q <= req_slot;
			box_q  <= {req_box_h, req_box_w, req_pos_y, req_pos_x};
			attr_q <= {req_has_handler, req_kind};
		end
		if (box_we) begin
			box_mem[wr_addr] <= box_q;
		end
		if (attr_we) begin
			attr_mem[wr_addr] <= attr_q;
		end
		if (rd_en) begin
			rd_box_s1  <= box_mem[rd_addr];
			rd_attr_s1 <= attr_mem[rd_addr];
		end
		if (cmd.row_ld) begin
			row_box_q  <= rd_box_s1;
			row_attr_q <= rd_attr_s1;
		end
		if (cmd.row_rd) begin
			idx_q <= CW'(slot_q) + CW'(1);
		end else if (cmd.advance && !idx_end) begin
			idx_q <= idx_q + CW'(1);
		end
		if (cmd.advance && !idx_end) begin
			idx_s1 <= idx_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (cmd.commit && (mode_q == MODE_ADD) && !full) begin
				used_q[free_idx] <= 1'b1;
			end else if (cmd.commit && (mode_q == MODE_ERASE) && present) begin
				used_q[slot_q[IW-1:0]] <= 1'b0;
			end
			if (cmd.row_rd) begin
				vld_s1 <= 1'b0;
			end else if (cmd.advance) begin
				vld_s1 <= !idx_end;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit || cmd.fin || pair_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		priority if (cmd.commit) begin
			out_kind_q   <= st_kind;
			out_status_q <= st_status;
			out_a_q      <= st_a;
			out_b_q      <= 6'd0;
			out_na_q     <= 1'b0;
			out_nb_q     <= 1'b0;
			out_last_q   <= 1'b1;
		end else if (pair_ld) begin
			out_kind_q   <= ITEM_PAIR;
			out_status_q <= ST_OK;
			out_a_q      <= slot_q;
			out_b_q      <= 6'(idx_s1);
			out_na_q     <= mask_hit(row_attr_q[3:0], rd_attr_s1[3:0]) && row_attr_q[4];
			out_nb_q     <= mask_hit(rd_attr_s1[3:0], row_attr_q[3:0]) && rd_attr_s1[4];
			out_last_q   <= 1'b0;
		end else if (cmd.fin) begin
			out_kind_q   <= ITEM_DONE;
			out_status_q <= ST_OK;
			out_a_q      <= slot_q;
			out_b_q      <= 6'd0;
			out_na_q     <= 1'b0;
			out_nb_q     <= 1'b0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_item_kind = out_kind_q;
	assign out_status    = out_status_q;
	assign out_slot_a    = out_a_q;
	assign out_slot_b    = out_b_q;
	assign out_notify_a  = out_na_q;
	assign out_notify_b  = out_nb_q;
	assign out_last      = out_last_q;

endmodule
